### rtl/core/vsis_pkg.sv
// ----------------------------------------------------------------------------
// vsis_pkg
// Shared types and constants for the scanline interrupt sequencer.
// ----------------------------------------------------------------------------
package vsis_pkg;

   // Active display heights for 50 Hz and 60 Hz timing
   localparam logic [8:0] ACTIVE_PAL  = 9'd240;
   localparam logic [8:0] ACTIVE_NTSC = 9'd224;

   // Configuration register indexes
   localparam logic [1:0] CSR_PAL_MODE    = 2'd0;
   localparam logic [1:0] CSR_LINE_IRQ_EN = 2'd1;
   localparam logic [1:0] CSR_VBL_IRQ_EN  = 2'd2;
   localparam logic [1:0] CSR_LINE_RELOAD = 2'd3;

   // Configuration register set
   typedef struct packed {
      logic       pal_mode;
      logic       line_irq_enable;
      logic       vblank_irq_enable;
      logic [7:0] line_counter_reload;
   } cfg_type;

   // One scanline tick request
   typedef struct packed {
      logic render_frame;
      logic vint_pending_in;
   } req_type;

   // One scanline result
   typedef struct packed {
      logic [8:0]  line_number;
      logic        render_line;
      logic        hint_set;
      logic        cpu_irq4_request;
      logic        vint_raise;
      logic        z80_irq_level;
      logic [20:0] cpu_run_until;
      logic        frame_end;
   } rsp_type;

endpackage

### rtl/core/vdp_scanline_interrupt_sequencer.sv
// ----------------------------------------------------------------------------
// vdp_scanline_interrupt_sequencer
// Scanline tick sequencer for line and vertical interrupts.
// ----------------------------------------------------------------------------
// One request on req_ is one video scanline tick; each produces exactly one
// response on rsp_ carrying the line handled, interrupt flags, the sound CPU
// interrupt level and the CPU run target for the line. rsp_tlast marks the
// last line of a frame, after which the line count wraps to 0.
// Requests land in a two-entry queue; the line engine takes one per cycle
// into the response register while that register is empty or rsp_tready is
// high, so a request passes a queue slot and then the response register.
// Throughput is one line per cycle under the same condition, set by the
// combinational counter/compare/multiply path of the line engine.
// When rsp_tready is low the response holds and the queue keeps filling;
// req_tready drops once both queue entries are taken.
// The user writes configuration on csr_ (index 0 pal_mode, 1 line irq enable,
// 2 vblank irq enable, 3 line counter reload) only while no tick is in flight.
// The block does not enforce this. Synchronous reset clears the configuration,
// line count, down counter, sound CPU level and both queue and response valid state.
// ----------------------------------------------------------------------------
module vdp_scanline_interrupt_sequencer #(
   parameter int LINES_PAL       = 313,
   parameter int LINES_NTSC      = 262,
   parameter int CYCLES_PER_LINE = 3420
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] render_frame, [1] vint_pending_in, zero fill
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [8:0] line_number, [9] render_line, [10] hint_set,
                                    // [11] cpu_irq4_request, [12] vint_raise,
                                    // [13] z80_irq_level, [34:14] cpu_run_until, zero fill
   output logic        rsp_tlast,   // frame_end
   // configuration port
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   vsis_pkg::cfg_type cfg_ff, cfg_in;
   vsis_pkg::req_type in_req;
   vsis_pkg::req_type q_req;
   vsis_pkg::rsp_type rsp;
   logic              q_valid;
   logic              q_pop;

   // Configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            vsis_pkg::CSR_PAL_MODE:    cfg_in.pal_mode            = csr_wdata[0];
            vsis_pkg::CSR_LINE_IRQ_EN: cfg_in.line_irq_enable     = csr_wdata[0];
            vsis_pkg::CSR_VBL_IRQ_EN:  cfg_in.vblank_irq_enable   = csr_wdata[0];
            vsis_pkg::CSR_LINE_RELOAD: cfg_in.line_counter_reload = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Request unpacking
   assign in_req.render_frame    = req_tdata[0];
   assign in_req.vint_pending_in = req_tdata[1];

   vsis_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_req   (in_req),
      .q_valid  (q_valid),
      .q_pop    (q_pop),
      .q_req    (q_req)
   );

   vsis_back #(
      .LINES_PAL       (LINES_PAL),
      .LINES_NTSC      (LINES_NTSC),
      .CYCLES_PER_LINE (CYCLES_PER_LINE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_req     (q_req),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rsp   (rsp)
   );

   // Response packing
   assign rsp_tdata = {5'd0, rsp.cpu_run_until, rsp.z80_irq_level, rsp.vint_raise,
                       rsp.cpu_irq4_request, rsp.hint_set, rsp.render_line,
                       rsp.line_number};
   assign rsp_tlast = rsp.frame_end;

endmodule

### rtl/core/vsis_front.sv
// ----------------------------------------------------------------------------
// vsis_front
// Request front end: takes ticks and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module vsis_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  vsis_pkg::req_type in_req,
   output logic              q_valid,
   input  logic              q_pop,
   output vsis_pkg::req_type q_req
);

   vsis_pkg::req_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign in_ready = (count_ff != 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign q_req    = slot_ff[rd_ptr_ff];
   assign push     = in_valid & in_ready;
   assign pop      = q_pop & q_valid;

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_req;
      end
   end

endmodule

### rtl/core/vsis_back.sv
// ----------------------------------------------------------------------------
// vsis_back
// Scanline engine: line count, line interrupt down counter, sound CPU
// interrupt level, and the registered result stage.
// ----------------------------------------------------------------------------
module vsis_back #(
   parameter int LINES_PAL       = 313,
   parameter int LINES_NTSC      = 262,
   parameter int CYCLES_PER_LINE = 3420
) (
   input  logic              clock,
   input  logic              reset,
   input  vsis_pkg::cfg_type cfg,
   input  logic              q_valid,
   output logic              q_pop,
   input  vsis_pkg::req_type q_req,
   output logic              out_valid,
   input  logic              out_ready,
   output vsis_pkg::rsp_type out_rsp
);

   localparam logic [8:0]  LinesPal  = 9'(LINES_PAL);
   localparam logic [8:0]  LinesNtsc = 9'(LINES_NTSC);
   localparam logic [31:0] CycLine   = 32'(CYCLES_PER_LINE);

   logic [8:0]        line_ff, line_in;
   logic signed [8:0] hint_cnt_ff, hint_cnt_in;
   logic              z80_ff, z80_in;
   logic              valid_ff, valid_in;
   vsis_pkg::rsp_type rsp_ff, rsp_in;

   logic [8:0]        height;
   logic [8:0]        lines;
   logic signed [8:0] cnt_cur;
   logic signed [8:0] cnt_dec;
   logic              underflow;
   logic [9:0]        next_line;
   logic [31:0]       run_prod;
   logic              hint;
   logic              fend;
   logic              step;

   assign step      = q_valid & (~valid_ff | out_ready);
   assign q_pop     = step;
   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

   // Per-line sequencing
   always_comb begin
      height    = cfg.pal_mode ? vsis_pkg::ACTIVE_PAL : vsis_pkg::ACTIVE_NTSC;
      lines     = cfg.pal_mode ? LinesPal : LinesNtsc;
      // reload on line 0 and past the first blanking line
      if ((line_ff == 9'd0) || (line_ff > height)) begin
         cnt_cur = $signed({1'b0, cfg.line_counter_reload});
      end else begin
         cnt_cur = hint_cnt_ff;
      end
      cnt_dec   = cnt_cur - 9'sd1;
      underflow = cnt_dec[8];
      hint      = underflow & cfg.line_irq_enable & (line_ff <= height);
      next_line = {1'b0, line_ff} + 10'd1;
      fend      = (next_line >= {1'b0, lines});
      run_prod  = 32'(next_line) * CycLine;

      z80_in = z80_ff;
      if (next_line == {1'b0, height}) begin
         z80_in = 1'b1;
      end else if (next_line == ({1'b0, height} + 10'd1)) begin
         z80_in = 1'b0;
      end

      hint_cnt_in = underflow ? $signed({1'b0, cfg.line_counter_reload}) : cnt_dec;
      line_in     = fend ? 9'd0 : next_line[8:0];

      rsp_in.line_number      = line_ff;
      rsp_in.render_line      = q_req.render_frame & (line_ff < height);
      rsp_in.hint_set         = hint;
      rsp_in.cpu_irq4_request = hint & ~q_req.vint_pending_in;
      rsp_in.vint_raise       = (next_line == {1'b0, height}) & cfg.vblank_irq_enable;
      rsp_in.z80_irq_level    = z80_in;
      rsp_in.cpu_run_until    = run_prod[20:0];
      rsp_in.frame_end        = fend;

      valid_in = step | (valid_ff & ~out_ready);
   end

   // Line state
   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff     <= 9'd0;
         hint_cnt_ff <= 9'sd0;
         z80_ff      <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (step) begin
            line_ff     <= line_in;
            hint_cnt_ff <= hint_cnt_in;
            z80_ff      <= z80_in;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

### sim/vdp_scanline_interrupt_sequencer_test.sv
// ----------------------------------------------------------------------------
// vdp_scanline_interrupt_sequencer_test
// Self-checking bench for the scanline interrupt sequencer.
// ----------------------------------------------------------------------------
// Scanline ticks go in on req_ and each response on rsp_ is checked field by
// field against an in-bench line predictor. A short directed plan covers reset
// state, line irqs with both pending states, the vblank line, a PAL to NTSC
// switch past the NTSC line total and register masking. Random phases with
// random register rewrites follow, with bursty requests, a stalling response
// side and long output hold-offs that back the block up.
// ----------------------------------------------------------------------------
module vdp_scanline_interrupt_sequencer_test;

   localparam int LINES_PAL       = 313;
   localparam int LINES_NTSC      = 262;
   localparam int CYCLES_PER_LINE = 3420;

   localparam int RANDOM_TICKS    = 674;
   localparam int DRAIN_CYCLES    = 4;     // response trails the request through the queue and response registers
   localparam int TAIL_CYCLES     = 8;
   localparam int IDLE_LIMIT      = 2000;  // cycles with no transfer at all
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int MAX_REPORTS     = 10;
   localparam int NUM_ROWS        = 21;

   typedef enum logic [1:0] {OP_TICK, OP_CHECK, OP_RUN, OP_CSR} plan_op_type;

   // one row of the directed plan
   typedef struct packed {
      plan_op_type       op;
      logic [1:0]        index;
      logic [7:0]        value;
      logic [15:0]       count;
      logic              render;
      logic              vpend;
      vsis_pkg::rsp_type line_rsp;
   } plan_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [0] render_frame, [1] vint_pending_in, zero fill
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // [8:0] line_number, [9] render_line, [10] hint_set,
                              // [11] cpu_irq4_request, [12] vint_raise,
                              // [13] z80_irq_level, [34:14] cpu_run_until, zero fill
   logic        rsp_tlast;    // frame_end
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [7:0]  csr_wdata;

   vdp_scanline_interrupt_sequencer #(
      .LINES_PAL      (LINES_PAL),
      .LINES_NTSC     (LINES_NTSC),
      .CYCLES_PER_LINE(CYCLES_PER_LINE)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // line predictor state
   vsis_pkg::cfg_type shadow_cfg = '0;
   logic [8:0]        line_cnt   = '0;
   int                hint_ctr   = 0;
   logic              z80_level  = 1'b0;
   vsis_pkg::rsp_type line_q[$];

   // expectation riding along with the current request
   bit                tick_typed = 1'b0;
   vsis_pkg::rsp_type tick_exp   = '0;

   int fault_count     = 0;
   int lines_checked   = 0;
   int frames          = 0;
   int hints           = 0;
   int vints           = 0;
   int mid_frame_wraps = 0;
   int csr_writes      = 0;
   int holdoffs        = 0;
   int idle_cycles     = 0;
   int burst_left      = 0;
   int rx_cyc          = 0;
   int hold_left       = 0;
   logic [20:0] max_run_until = '0;

   plan_row_type plan [NUM_ROWS];

   always #2 clock = ~clock;

   // --------------------------------------------------------------------------
   // line predictor: advances the shadow state by one scanline
   // --------------------------------------------------------------------------
   function automatic vsis_pkg::rsp_type predict_line(input logic render,
                                                      input logic vpend);
      int                lines;
      int                height;
      int                line;
      int                nxt;
      int                reload;
      vsis_pkg::rsp_type r;
      r      = '0;
      lines  = shadow_cfg.pal_mode ? LINES_PAL : LINES_NTSC;
      height = shadow_cfg.pal_mode ? int'(vsis_pkg::ACTIVE_PAL) : int'(vsis_pkg::ACTIVE_NTSC);
      reload = int'(shadow_cfg.line_counter_reload);
      line   = int'(line_cnt);
      // timing switched to a shorter frame while already past its end
      if (line >= lines) mid_frame_wraps++;

      // down counter reload on line 0 and past the first blanking line
      if (line == 0 || line > height) hint_ctr = reload;
      hint_ctr--;
      if (hint_ctr < 0) begin
         if (shadow_cfg.line_irq_enable && line <= height) begin
            r.hint_set         = 1'b1;
            r.cpu_irq4_request = !vpend;
         end
         hint_ctr = reload;
      end

      // vblank and sound cpu irq window
      nxt = line + 1;
      if (nxt == height) begin
         r.vint_raise = shadow_cfg.vblank_irq_enable;
         z80_level    = 1'b1;
      end
      if (nxt == height + 1) z80_level = 1'b0;

      if (nxt >= lines) begin
         r.frame_end = 1'b1;
         line_cnt    = '0;
      end else begin
         line_cnt = 9'(nxt);
      end

      r.line_number   = 9'(line);
      r.render_line   = render && (line < height);
      r.z80_irq_level = z80_level;
      r.cpu_run_until = 21'(nxt * CYCLES_PER_LINE);
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got, input int line);
      if (got !== want) begin
         fault_count++;
         if (fault_count <= MAX_REPORTS)
            $display("line %0d %s: expected %0d, got %0d", line, name, want, got);
      end
   endtask

   // --------------------------------------------------------------------------
   // monitor: register shadow, expected lines, response check, watchdog
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      vsis_pkg::rsp_type want;
      vsis_pkg::rsp_type got;
      vsis_pkg::rsp_type pred;
      bit                moved;
      if (!reset) begin
         moved = 1'b0;
         if (csr_wr_en) begin
            csr_writes++;
            case (csr_index)
               vsis_pkg::CSR_PAL_MODE:    shadow_cfg.pal_mode            = csr_wdata[0];
               vsis_pkg::CSR_LINE_IRQ_EN: shadow_cfg.line_irq_enable     = csr_wdata[0];
               vsis_pkg::CSR_VBL_IRQ_EN:  shadow_cfg.vblank_irq_enable   = csr_wdata[0];
               vsis_pkg::CSR_LINE_RELOAD: shadow_cfg.line_counter_reload = csr_wdata;
               default: ;
            endcase
         end

         if (req_tvalid && req_tready) begin
            pred = predict_line(req_tdata[0], req_tdata[1]);
            line_q.push_back(tick_typed ? tick_exp : pred);
            moved = 1'b1;
         end

         if (rsp_tvalid && rsp_tready) begin
            got.line_number      = rsp_tdata[8:0];
            got.render_line      = rsp_tdata[9];
            got.hint_set         = rsp_tdata[10];
            got.cpu_irq4_request = rsp_tdata[11];
            got.vint_raise       = rsp_tdata[12];
            got.z80_irq_level    = rsp_tdata[13];
            got.cpu_run_until    = rsp_tdata[34:14];
            got.frame_end        = rsp_tlast;
            if (line_q.size() == 0) begin
               fault_count++;
               if (fault_count <= MAX_REPORTS)
                  $display("unexpected response for line %0d", got.line_number);
            end else begin
               want = line_q.pop_front();
               lines_checked++;
               compare_field("line_number", 32'(want.line_number),
                             32'(got.line_number), want.line_number);
               compare_field("render_line", 32'(want.render_line),
                             32'(got.render_line), want.line_number);
               compare_field("hint_set", 32'(want.hint_set),
                             32'(got.hint_set), want.line_number);
               compare_field("cpu_irq4_request", 32'(want.cpu_irq4_request),
                             32'(got.cpu_irq4_request), want.line_number);
               compare_field("vint_raise", 32'(want.vint_raise),
                             32'(got.vint_raise), want.line_number);
               compare_field("z80_irq_level", 32'(want.z80_irq_level),
                             32'(got.z80_irq_level), want.line_number);
               compare_field("cpu_run_until", 32'(want.cpu_run_until),
                             32'(got.cpu_run_until), want.line_number);
               compare_field("frame_end", 32'(want.frame_end),
                             32'(got.frame_end), want.line_number);
            end
            if (got.frame_end) frames++;
            if (got.hint_set) hints++;
            if (got.vint_raise) vints++;
            if (got.cpu_run_until > max_run_until) max_run_until = got.cpu_run_until;
            moved = 1'b1;
         end

         // nothing moving for too long means the block is hung
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // --------------------------------------------------------------------------
   // response side: free-running, random and periodic stalls, long hold-offs
   // --------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_cyc++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rx_cyc % 400 == 150) begin
            hold_left = HOLD_OFF_CYCLES - 1;
            holdoffs++;
            rsp_tready <= 1'b0;
         end else begin
            case ((rx_cyc / 100) % 3)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 9) < 7);
               default: rsp_tready <= (rx_cyc % 5 != 2) && (rx_cyc % 7 != 0);
            endcase
         end
      end
   end

   // --------------------------------------------------------------------------
   // request side helpers
   // --------------------------------------------------------------------------
   // one scanline request, sent in bursts with random gaps
   task automatic send_tick(input logic render, input logic vpend,
                            input bit typed, input vsis_pkg::rsp_type exp);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
      end
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, vpend, render};
      tick_typed <= typed;
      tick_exp   <= exp;
      do @(posedge clock); while (!req_tready);
      burst_left--;
   endtask

   // registers change only with no line in flight
   task automatic write_csr(input logic [1:0] index, input logic [7:0] value);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (line_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic plan_row_type csr_row(input logic [1:0] index, input logic [7:0] value);
      plan_row_type row;
      row       = '0;
      row.op    = OP_CSR;
      row.index = index;
      row.value = value;
      return row;
   endfunction

   function automatic plan_row_type tick_row(input logic render, input logic vpend);
      plan_row_type row;
      row        = '0;
      row.op     = OP_TICK;
      row.render = render;
      row.vpend  = vpend;
      return row;
   endfunction

   function automatic plan_row_type check_row(input logic render, input logic vpend,
                                              input vsis_pkg::rsp_type exp);
      plan_row_type row;
      row          = '0;
      row.op       = OP_CHECK;
      row.render   = render;
      row.vpend    = vpend;
      row.line_rsp = exp;
      return row;
   endfunction

   function automatic plan_row_type run_row(input int n);
      plan_row_type row;
      row       = '0;
      row.op    = OP_RUN;
      row.count = 16'(n);
      return row;
   endfunction

   // --------------------------------------------------------------------------
   // stimulus
   // --------------------------------------------------------------------------
   initial begin
      int          rand_ticks;
      int          phase_len;
      logic [7:0]  reload;
      int          leftover;
      clock      = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_wr_en  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      rand_ticks = 0;

      // fields: line, render, hint, irq4, vint, z80, run_until, frame_end
      plan = '{
         // reset state: NTSC, irqs off, reload 0
         check_row(1'b1, 1'b0, vsis_pkg::rsp_type'{9'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                                                   21'd3420, 1'b0}),
         check_row(1'b0, 1'b1, vsis_pkg::rsp_type'{9'd1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                                   21'd6840, 1'b0}),
         // line irq every line, with and without vblank pending
         csr_row(vsis_pkg::CSR_LINE_IRQ_EN, 8'h01),
         csr_row(vsis_pkg::CSR_LINE_RELOAD, 8'h00),
         check_row(1'b1, 1'b0, vsis_pkg::rsp_type'{9'd2, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
                                                   21'd10260, 1'b0}),
         check_row(1'b1, 1'b1, vsis_pkg::rsp_type'{9'd3, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
                                                   21'd13680, 1'b0}),
         csr_row(vsis_pkg::CSR_LINE_RELOAD, 8'hFF),
         tick_row(1'b0, 1'b0),
         // PAL with vblank irq; upper data bits are masked off
         csr_row(vsis_pkg::CSR_PAL_MODE, 8'hFF),
         csr_row(vsis_pkg::CSR_VBL_IRQ_EN, 8'h01),
         csr_row(vsis_pkg::CSR_LINE_RELOAD, 8'h07),
         run_row(234),
         tick_row(1'b1, 1'b0),
         tick_row(1'b1, 1'b1),
         run_row(30),
         // back to NTSC while at line 271, past the NTSC frame end
         csr_row(vsis_pkg::CSR_PAL_MODE, 8'hFE),
         check_row(1'b1, 1'b0, vsis_pkg::rsp_type'{9'd271, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                                   21'd930240, 1'b1}),
         check_row(1'b1, 1'b0, vsis_pkg::rsp_type'{9'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                                                   21'd3420, 1'b0}),
         csr_row(vsis_pkg::CSR_VBL_IRQ_EN, 8'h00),
         csr_row(vsis_pkg::CSR_LINE_IRQ_EN, 8'h00),
         run_row(3)
      };

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed plan
      for (int i = 0; i < NUM_ROWS; i++) begin
         case (plan[i].op)
            OP_CSR:   write_csr(plan[i].index, plan[i].value);
            OP_TICK:  send_tick(plan[i].render, plan[i].vpend, 1'b0, '0);
            OP_CHECK: send_tick(plan[i].render, plan[i].vpend, 1'b1, plan[i].line_rsp);
            default: begin
               repeat (int'(plan[i].count))
                  send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
            end
         endcase
      end

      // random phases, each possibly under a new register setting
      while (rand_ticks < RANDOM_TICKS) begin
         if ($urandom_range(0, 1) == 1) write_csr(vsis_pkg::CSR_PAL_MODE, 8'($urandom));
         if ($urandom_range(0, 1) == 1) write_csr(vsis_pkg::CSR_LINE_IRQ_EN, 8'($urandom));
         if ($urandom_range(0, 1) == 1) write_csr(vsis_pkg::CSR_VBL_IRQ_EN, 8'($urandom));
         if ($urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 4))
               0:       reload = 8'h00;
               1:       reload = 8'hFF;
               2:       reload = 8'($urandom_range(1, 15));
               default: reload = 8'($urandom);
            endcase
            write_csr(vsis_pkg::CSR_LINE_RELOAD, reload);
         end
         phase_len = ($urandom_range(0, 4) == 0) ? $urandom_range(150, 320)
                                                 : $urandom_range(10, 90);
         if (phase_len > RANDOM_TICKS - rand_ticks) phase_len = RANDOM_TICKS - rand_ticks;
         repeat (phase_len) begin
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
            rand_ticks++;
         end
      end

      // drain and let the pipeline settle
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (line_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      leftover = line_q.size();
      if (leftover != 0) begin
         $display("%0d expected lines never came out", leftover);
         fault_count += leftover;
      end

      $display("checked %0d lines, %0d frame wraps (%0d after a timing switch), max run %0d",
               lines_checked, frames, mid_frame_wraps, max_run_until);
      $display("%0d line irqs, %0d vblank irqs, %0d register writes, %0d long output stalls",
               hints, vints, csr_writes, holdoffs);
      if (fault_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", fault_count);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/vsis_pkg.sv
rtl/core/vsis_front.sv
rtl/core/vsis_back.sv
rtl/core/vdp_scanline_interrupt_sequencer.sv
sim/vdp_scanline_interrupt_sequencer_test.sv
